@@ rtl/core/md5_pkg.sv @@
// md5_pkg: types, constants and helper functions shared by the md5 core
// used by md5_ctrl, md5_datapath and md5_message_digest_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 64;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] FILL_LAST  = 6'h3f;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [3:0] LEN_WORD   = 4'd14;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] STEP_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } md5_req_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic        part_index;
      logic        last_part;
   } md5_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_FOLD,
      ST_EMIT0,
      ST_EMIT1
   } md5_state_type;

   // how the block words are formed for a compression
   typedef enum logic [1:0] {
      MODE_DATA,
      MODE_MARK_LEN,
      MODE_MARK,
      MODE_LEN
   } md5_mode_type;

   typedef struct packed {
      logic         byte_write;
      logic         load;
      logic         step;
      logic         fold;
      logic         clear;
      logic         part_sel;
      md5_mode_type mode;
   } md5_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_high;
      logic round_last;
   } md5_status_type;

   // message word used by a given round
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] lo;
      logic [3:0] g;
      lo = r[3:0];
      unique case (r[5:4])
         2'd0: g = lo;
         2'd1: g = 4'({lo, 2'b00} + lo + 4'd1);
         2'd2: g = 4'({lo, 1'b0} + lo + 4'd5);
         default: g = 4'({lo, 3'b000} - lo);
      endcase
      return g;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] wide;
      wide = {v, v} << s;
      return wide[63:32];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/md5_ctrl.sv @@
// md5_ctrl: sequencer for byte intake, compression rounds, padding blocks and digest beats
// depends on md5_pkg
`timescale 1ns / 1ps
`default_nettype none

module md5_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_kind,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire md5_pkg::md5_status_type status,
   output md5_pkg::md5_cmd_type         cmd
);

   md5_pkg::md5_state_type state_ff, state_in;
   md5_pkg::md5_mode_type  mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         mode_ff  <= md5_pkg::MODE_DATA;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind) begin
                  state_in = md5_pkg::ST_LOAD;
                  mode_in  = status.fill_high ? md5_pkg::MODE_MARK : md5_pkg::MODE_MARK_LEN;
               end else if (status.fill_last) begin
                  state_in = md5_pkg::ST_LOAD;
                  mode_in  = md5_pkg::MODE_DATA;
               end
            end
         end
         md5_pkg::ST_LOAD: state_in = md5_pkg::ST_RUN;
         md5_pkg::ST_RUN: begin
            if (status.round_last) state_in = md5_pkg::ST_FOLD;
         end
         md5_pkg::ST_FOLD: begin
            unique case (mode_ff)
               md5_pkg::MODE_DATA: state_in = md5_pkg::ST_IDLE;
               md5_pkg::MODE_MARK: begin
                  // length did not fit, one more block of zeros and length
                  state_in = md5_pkg::ST_LOAD;
                  mode_in  = md5_pkg::MODE_LEN;
               end
               default: state_in = md5_pkg::ST_EMIT0;
            endcase
         end
         md5_pkg::ST_EMIT0: begin
            if (!rsp_stall) state_in = md5_pkg::ST_EMIT1;
         end
         md5_pkg::ST_EMIT1: begin
            if (!rsp_stall) begin
               state_in = md5_pkg::ST_IDLE;
               mode_in  = md5_pkg::MODE_DATA;
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.mode      = mode_ff;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.byte_write = req_valid & ~req_kind;
         end
         md5_pkg::ST_LOAD: cmd.load = 1'b1;
         md5_pkg::ST_RUN:  cmd.step = 1'b1;
         md5_pkg::ST_FOLD: cmd.fold = 1'b1;
         md5_pkg::ST_EMIT0: rsp_valid = 1'b1;
         md5_pkg::ST_EMIT1: begin
            rsp_valid    = 1'b1;
            cmd.part_sel = 1'b1;
            cmd.clear    = ~rsp_stall;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/md5_datapath.sv @@
// md5_datapath: block word store, byte counter, round unit and chaining words
// depends on md5_pkg
`timescale 1ns / 1ps
`default_nettype none

module md5_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           data_byte,
   input  wire md5_pkg::md5_cmd_type cmd,
   output md5_pkg::md5_status_type   status,
   output logic [63:0]               digest_part
);

   logic [3:0][7:0] blk_word_ff [md5_pkg::BLOCK_WORDS];
   logic [31:0]     chain_ff [4];
   logic [63:0]     byte_total_ff, byte_total_in;
   logic [31:0]     a_ff, b_ff, c_ff, d_ff;
   logic [31:0]     a_in, b_in, c_in, d_in;
   logic [31:0]     wk_ff, wk_in;
   logic [5:0]      round_ff, round_in;

   logic [5:0]      fill;
   logic [63:0]     len_bits;
   logic [5:0]      fetch_round;
   logic [3:0]      fetch_index;
   logic [31:0]     fetch_word;
   logic [31:0]     mix;
   logic [31:0]     rot_in;
   logic [3:0]      rot_sel;

   assign fill     = byte_total_ff[5:0];
   assign len_bits = {byte_total_ff[60:0], 3'b000};

   assign status.fill_last  = (fill == md5_pkg::FILL_LAST);
   assign status.fill_high  = (fill >= md5_pkg::LEN_OFFSET);
   assign status.round_last = (round_ff == md5_pkg::ROUND_LAST);

   // word for the next round, with padding applied on the fly
   assign fetch_round = cmd.load ? '0 : 6'(round_ff + 6'd1);
   assign fetch_index = md5_pkg::msg_index(fetch_round);

   always_comb begin
      logic [3:0][7:0] raw;
      logic [5:0]      pos;
      raw = blk_word_ff[fetch_index];
      for (int k = 0; k < 4; k++) begin
         pos = {fetch_index, 2'(k)};
         fetch_word[8*k +: 8] = raw[k];
         if (cmd.mode == md5_pkg::MODE_MARK || cmd.mode == md5_pkg::MODE_MARK_LEN) begin
            if (pos == fill) fetch_word[8*k +: 8] = md5_pkg::PAD_MARK;
            else if (pos > fill) fetch_word[8*k +: 8] = 8'h00;
         end else if (cmd.mode == md5_pkg::MODE_LEN) begin
            fetch_word[8*k +: 8] = 8'h00;
         end
      end
      if ((cmd.mode == md5_pkg::MODE_LEN || cmd.mode == md5_pkg::MODE_MARK_LEN)
          && fetch_index >= md5_pkg::LEN_WORD) begin
         fetch_word = fetch_index[0] ? len_bits[63:32] : len_bits[31:0];
      end
   end

   assign wk_in = fetch_word + md5_pkg::STEP_CONST[fetch_round];

   // one compression round
   always_comb begin
      unique case (round_ff[5:4])
         2'd0: mix = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1: mix = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2: mix = b_ff ^ c_ff ^ d_ff;
         default: mix = c_ff ^ (b_ff | ~d_ff);
      endcase
   end

   assign rot_in  = a_ff + mix + wk_ff;
   assign rot_sel = {round_ff[5:4], round_ff[1:0]};

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      round_in = round_ff;
      if (cmd.load) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         round_in = '0;
      end else if (cmd.step) begin
         a_in     = d_ff;
         d_in     = c_ff;
         c_in     = b_ff;
         b_in     = b_ff + md5_pkg::rotl32(rot_in, md5_pkg::ROT_AMOUNT[rot_sel]);
         round_in = 6'(round_ff + 6'd1);
      end
   end

   always_comb begin
      byte_total_in = byte_total_ff;
      if (cmd.clear) byte_total_in = '0;
      else if (cmd.byte_write) byte_total_in = byte_total_ff + 64'd1;
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      round_ff <= round_in;
      wk_ff    <= wk_in;
      if (cmd.byte_write) blk_word_ff[fill[5:2]][fill[1:0]] <= data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         byte_total_ff <= '0;
         for (int i = 0; i < 4; i++) chain_ff[i] <= md5_pkg::CHAIN_INIT[i];
      end else begin
         byte_total_ff <= byte_total_in;
         if (cmd.fold) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
      end
   end

   assign digest_part = cmd.part_sel ? {chain_ff[3], chain_ff[2]} : {chain_ff[1], chain_ff[0]};

endmodule

`default_nettype wire

@@ rtl/core/md5_message_digest_top.sv @@
// md5 core: a data beat is taken while the sequencer is idle; the 64th byte of a block stalls input
// through the load, 64 rounds on one shared round unit and the fold into the chaining words
// finish: one or two padding compressions, then two digest beats
// throughput: one byte per cycle between blocks
// reset: chaining words to their initial values, byte count zero, sequencer idle
// depends on md5_pkg, md5_ctrl, md5_datapath
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire md5_pkg::md5_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output md5_pkg::md5_rsp_type      rsp_data
);

   md5_pkg::md5_cmd_type    cmd;
   md5_pkg::md5_status_type status;
   logic [63:0]             digest_part;

   md5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   md5_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data.data_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_part (digest_part)
   );

   assign rsp_data.digest_part = digest_part;
   assign rsp_data.part_index  = cmd.part_sel;
   assign rsp_data.last_part   = cmd.part_sel;

endmodule

`default_nettype wire
